[hw/rtl/pcsw_pkg.sv]
// pcsw_pkg: shared constants, types and helpers of the piece count / stable weigh core
// used by pcsw_count_unit, pcsw_still_track and piece_count_stable_weigh_core
// no dependencies
package pcsw_pkg;

    // sizing constants
    localparam int MAX_PIECES    = 1023;
    localparam int WEIGHT_BITS   = 20;
    localparam int MAG_W         = WEIGHT_BITS - 1;
    localparam int CFG_W         = 16;
    localparam int NEED_W        = 8;
    localparam int HELD_W        = 19;
    localparam int COUNT_W       = 10;
    localparam int COUNT_OUT_MAX = 1023;
    localparam int CFG_IDX_W     = 3;
    localparam int STEP_W        = $clog2(MAX_PIECES + 1);
    localparam int CMP_W         = (STEP_W > COUNT_W) ? STEP_W : COUNT_W;
    localparam int DIFF_W        = (MAG_W > CFG_W) ? MAG_W : CFG_W;
    localparam int REM_W         = ((WEIGHT_BITS > 18) ? WEIGHT_BITS : 18) + 2;
    localparam logic [NEED_W-1:0] RUN_MAX = '1;

    // configuration register indexes
    typedef enum logic [CFG_IDX_W-1:0] {
        REG_PIECE_AVERAGE      = 3'd0,
        REG_PIECE_TOLERANCE    = 3'd1,
        REG_ODD_LOW_OFFSET     = 3'd2,
        REG_ODD_HIGH_OFFSET    = 3'd3,
        REG_STILL_THRESHOLD    = 3'd4,
        REG_STILL_COUNT_NEEDED = 3'd5
    } cfg_reg_t;

    // top level sequencer states
    typedef enum logic {
        S_IDLE,
        S_COUNT
    } state_t;

    // counting settings handed to the count unit (offsets are two's complement)
    typedef struct packed {
        logic [CFG_W-1:0] average;
        logic [CFG_W-1:0] tolerance;
        logic [CFG_W-1:0] odd_low;
        logic [CFG_W-1:0] odd_high;
    } count_cfg_t;

    // count unit status back to the sequencer
    typedef struct packed {
        logic              busy;
        logic              capped;
        logic [STEP_W-1:0] normal;
        logic [STEP_W-1:0] odd;
        logic [STEP_W-1:0] steps;
    } count_stat_t;

    // clip a raw count to the output field range
    function automatic logic [COUNT_W-1:0] sat_count(input logic [STEP_W-1:0] c);
        logic [CMP_W-1:0] wide;
        wide = CMP_W'(c);
        if (wide > CMP_W'(COUNT_OUT_MAX)) begin
            return COUNT_W'(COUNT_OUT_MAX);
        end
        return COUNT_W'(wide);
    endfunction

endpackage

[hw/rtl/pcsw_count_unit.sv]
// pcsw_count_unit: iterative piece counter, one compare/subtract step per cycle
// depends on pcsw_pkg
module pcsw_count_unit
    import pcsw_pkg::*;
(
    input  logic             aclk,
    input  logic             aresetn,
    input  logic             start,
    input  logic [MAG_W-1:0] sample,
    input  count_cfg_t       cfg,
    output count_stat_t      stat
);

    logic                     busy_reg, busy_next;
    logic                     capped_reg, capped_next;
    logic [STEP_W-1:0]        normal_reg, normal_next;
    logic [STEP_W-1:0]        odd_reg, odd_next;
    logic [STEP_W-1:0]        steps_reg, steps_next;
    logic signed [REM_W-1:0]  rem_reg, rem_next;
    logic signed [REM_W-1:0]  avg_reg, avg_next;
    logic signed [REM_W-1:0]  margin_reg, margin_next;
    logic signed [REM_W-1:0]  odd_lo_reg, odd_lo_next;
    logic signed [REM_W-1:0]  odd_hi_reg, odd_hi_next;
    logic signed [REM_W-1:0]  avg_ext, tol_ext, low_ext, high_ext;
    logic                     go, in_window;

    // widen settings to the remainder width
    assign avg_ext  = $signed({{(REM_W-CFG_W){1'b0}}, cfg.average});
    assign tol_ext  = $signed({{(REM_W-CFG_W){1'b0}}, cfg.tolerance});
    assign low_ext  = $signed({{(REM_W-CFG_W){cfg.odd_low[CFG_W-1]}}, cfg.odd_low});
    assign high_ext = $signed({{(REM_W-CFG_W){cfg.odd_high[CFG_W-1]}}, cfg.odd_high});

    // step conditions on the current remainder
    assign go        = rem_reg >= margin_reg;
    assign in_window = (rem_reg >= odd_lo_reg) && (rem_reg <= odd_hi_reg);

    // next state of the counting loop
    always_comb begin
        busy_next   = busy_reg;
        capped_next = capped_reg;
        normal_next = normal_reg;
        odd_next    = odd_reg;
        steps_next  = steps_reg;
        rem_next    = rem_reg;
        avg_next    = avg_reg;
        margin_next = margin_reg;
        odd_lo_next = odd_lo_reg;
        odd_hi_next = odd_hi_reg;
        if (start) begin
            busy_next   = 1'b1;
            capped_next = 1'b0;
            normal_next = '0;
            odd_next    = '0;
            steps_next  = '0;
            rem_next    = $signed({{(REM_W-MAG_W){1'b0}}, sample});
            avg_next    = avg_ext;
            margin_next = avg_ext - tol_ext;
            odd_lo_next = avg_ext + low_ext;
            odd_hi_next = avg_ext + high_ext;
        end else if (busy_reg) begin
            if (!go) begin
                busy_next = 1'b0;
            end else if (steps_reg == STEP_W'(MAX_PIECES)) begin
                busy_next   = 1'b0;
                capped_next = 1'b1;
            end else begin
                if (in_window) begin
                    odd_next = odd_reg + STEP_W'(1);
                end else begin
                    normal_next = normal_reg + STEP_W'(1);
                end
                steps_next = steps_reg + STEP_W'(1);
                rem_next   = rem_reg - avg_reg;
            end
        end
    end

    // control registers
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg   <= 1'b0;
            capped_reg <= 1'b0;
            normal_reg <= '0;
            odd_reg    <= '0;
            steps_reg  <= '0;
        end else begin
            busy_reg   <= busy_next;
            capped_reg <= capped_next;
            normal_reg <= normal_next;
            odd_reg    <= odd_next;
            steps_reg  <= steps_next;
        end
    end

    // datapath registers
    always_ff @(posedge aclk) begin
        rem_reg    <= rem_next;
        avg_reg    <= avg_next;
        margin_reg <= margin_next;
        odd_lo_reg <= odd_lo_next;
        odd_hi_reg <= odd_hi_next;
    end

    assign stat.busy   = busy_reg;
    assign stat.capped = capped_reg;
    assign stat.normal = normal_reg;
    assign stat.odd    = odd_reg;
    assign stat.steps  = steps_reg;

`ifndef NO_ASSERTIONS
    // step counter always equals the two class counters together
    a_steps_sum: assert property (@(posedge aclk) disable iff (!aresetn)
        steps_reg == normal_reg + odd_reg)
        else $error("step count differs from normal plus odd");

    // the cap flag only rises with the step counter at its limit
    a_cap_steps: assert property (@(posedge aclk) disable iff (!aresetn)
        capped_reg |-> steps_reg == STEP_W'(MAX_PIECES))
        else $error("cap flag set below the step limit");
`endif

endmodule

[hw/rtl/pcsw_still_track.sv]
// pcsw_still_track: sample-to-sample stillness detector and held weight register
// depends on pcsw_pkg
module pcsw_still_track
    import pcsw_pkg::*;
(
    input  logic              aclk,
    input  logic              aresetn,
    input  logic              update,
    input  logic [MAG_W-1:0]  sample,
    input  logic [CFG_W-1:0]  still_threshold,
    input  logic [NEED_W-1:0] still_count_needed,
    output logic [MAG_W-1:0]  held_weight,
    output logic              is_still
);

    logic [MAG_W-1:0]  last_reg, last_next;
    logic [NEED_W-1:0] run_reg, run_next;
    logic [MAG_W-1:0]  held_reg, held_next;
    logic              still_reg, still_next;
    logic [MAG_W-1:0]  diff;
    logic [NEED_W-1:0] run_inc;

    // absolute change against the previous sample
    assign diff    = (sample >= last_reg) ? (sample - last_reg) : (last_reg - sample);
    assign run_inc = (run_reg == RUN_MAX) ? run_reg : run_reg + NEED_W'(1);

    // run counter and hold update
    always_comb begin
        last_next  = last_reg;
        run_next   = run_reg;
        held_next  = held_reg;
        still_next = DIFF_W'(diff) <= DIFF_W'(still_threshold);
        if (update) begin
            last_next = sample;
            if (still_next) begin
                run_next = run_inc;
                if (run_inc >= still_count_needed) begin
                    held_next = sample;
                    run_next  = still_count_needed;
                end
            end else begin
                run_next = '0;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            last_reg  <= '0;
            run_reg   <= '0;
            held_reg  <= '0;
            still_reg <= 1'b0;
        end else begin
            last_reg <= last_next;
            run_reg  <= run_next;
            held_reg <= held_next;
            if (update) begin
                still_reg <= still_next;
            end
        end
    end

    assign held_weight = held_reg;
    assign is_still    = still_reg;

`ifndef NO_ASSERTIONS
    // a moving sample restarts the run
    a_run_clear: assert property (@(posedge aclk) disable iff (!aresetn)
        update && !still_next |=> run_reg == '0)
        else $error("run not cleared on a moving sample");

    // a moving sample never changes the held weight
    a_hold_keep: assert property (@(posedge aclk) disable iff (!aresetn)
        update && !still_next |=> $stable(held_reg))
        else $error("held weight changed on a moving sample");
`endif

endmodule

[hw/rtl/piece_count_stable_weigh_core.sv]
// piece_count_stable_weigh_core: top level, config registers, sequencer, result register
// depends on pcsw_pkg, pcsw_count_unit, pcsw_still_track
//
//  channel   signals                          direction  accepted when
//  s_        s_valid s_ready s_sample_weight  in         s_valid && s_ready
//  m_        m_valid m_ready m_* result       out        m_valid && m_ready
//  cfg_      cfg_we cfg_addr cfg_wdata        in         cfg_we
//
// the count unit counts a sample with one compare/subtract step per piece counted
// (at most MAX_PIECES steps; a sample with more pieces is flagged as capped)
// synchronous active-low reset clears all control state and stable-weight history
// s_ready is high only while no sample is in work; a result waiting on m_ready
// does not block the next sample, only the handoff of the one after it
module piece_count_stable_weigh_core
    import pcsw_pkg::*;
(
    input  logic                   aclk,
    input  logic                   aresetn,
    input  logic                   s_valid,
    output logic                   s_ready,
    input  logic [WEIGHT_BITS-1:0] s_sample_weight,
    output logic                   m_valid,
    input  logic                   m_ready,
    output logic [HELD_W-1:0]      m_held_weight_out,
    output logic [COUNT_W-1:0]     m_normal_count,
    output logic [COUNT_W-1:0]     m_odd_count,
    output logic [COUNT_W-1:0]     m_total_count,
    output logic                   m_is_still,
    output logic                   m_count_capped,
    input  logic                   cfg_we,
    input  logic [CFG_IDX_W-1:0]   cfg_addr,
    input  logic [CFG_W-1:0]       cfg_wdata
);

    logic [CFG_W-1:0]  avg_reg, tol_reg, low_reg, high_reg, thr_reg;
    logic [NEED_W-1:0] need_reg;
    state_t            state_reg, state_next;
    logic              m_valid_reg, m_valid_next;
    logic              load_out;
    logic              accept;
    logic [MAG_W-1:0]  sample_mag;
    count_cfg_t        cnt_cfg;
    count_stat_t       cnt_stat;
    logic [MAG_W-1:0]  held_weight;
    logic              is_still;
    logic [HELD_W-1:0] held_out_reg;
    logic [COUNT_W-1:0] normal_out_reg, odd_out_reg, total_out_reg;
    logic              still_out_reg, capped_out_reg;

    // configuration registers
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            avg_reg  <= CFG_W'(100);
            tol_reg  <= CFG_W'(10);
            low_reg  <= CFG_W'(20);
            high_reg <= CFG_W'(40);
            thr_reg  <= CFG_W'(5);
            need_reg <= NEED_W'(10);
        end else if (cfg_we) begin
            unique case (cfg_reg_t'(cfg_addr))
                REG_PIECE_AVERAGE:      avg_reg  <= cfg_wdata;
                REG_PIECE_TOLERANCE:    tol_reg  <= cfg_wdata;
                REG_ODD_LOW_OFFSET:     low_reg  <= cfg_wdata;
                REG_ODD_HIGH_OFFSET:    high_reg <= cfg_wdata;
                REG_STILL_THRESHOLD:    thr_reg  <= cfg_wdata;
                REG_STILL_COUNT_NEEDED: need_reg <= cfg_wdata[NEED_W-1:0];
                default: ;
            endcase
        end
    end

    // negative samples clamp to zero
    assign sample_mag = s_sample_weight[WEIGHT_BITS-1] ? '0 : s_sample_weight[MAG_W-1:0];

    assign cnt_cfg.average   = avg_reg;
    assign cnt_cfg.tolerance = tol_reg;
    assign cnt_cfg.odd_low   = low_reg;
    assign cnt_cfg.odd_high  = high_reg;

    assign s_ready = (state_reg == S_IDLE);
    assign accept  = s_valid && s_ready;

    pcsw_count_unit u_count (
        .aclk    (aclk),
        .aresetn (aresetn),
        .start   (accept),
        .sample  (sample_mag),
        .cfg     (cnt_cfg),
        .stat    (cnt_stat)
    );

    pcsw_still_track u_still (
        .aclk               (aclk),
        .aresetn            (aresetn),
        .update             (accept),
        .sample             (sample_mag),
        .still_threshold    (thr_reg),
        .still_count_needed (need_reg),
        .held_weight        (held_weight),
        .is_still           (is_still)
    );

    // sequencer state register
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= S_IDLE;
            m_valid_reg <= 1'b0;
        end else begin
            state_reg   <= state_next;
            m_valid_reg <= m_valid_next;
        end
    end

    // next state and result register handoff
    always_comb begin
        state_next   = state_reg;
        m_valid_next = m_valid_reg;
        load_out     = 1'b0;
        if (m_valid_reg && m_ready) begin
            m_valid_next = 1'b0;
        end
        unique case (state_reg)
            S_IDLE: begin
                if (accept) begin
                    state_next = S_COUNT;
                end
            end
            S_COUNT: begin
                if (!cnt_stat.busy && (!m_valid_reg || m_ready)) begin
                    load_out     = 1'b1;
                    m_valid_next = 1'b1;
                    state_next   = S_IDLE;
                end
            end
            default: state_next = S_IDLE;
        endcase
    end

    // result word register
    always_ff @(posedge aclk) begin
        if (load_out) begin
            held_out_reg   <= HELD_W'(held_weight);
            normal_out_reg <= sat_count(cnt_stat.normal);
            odd_out_reg    <= sat_count(cnt_stat.odd);
            total_out_reg  <= sat_count(cnt_stat.steps);
            still_out_reg  <= is_still;
            capped_out_reg <= cnt_stat.capped;
        end
    end

    assign m_valid           = m_valid_reg;
    assign m_held_weight_out = held_out_reg;
    assign m_normal_count    = normal_out_reg;
    assign m_odd_count       = odd_out_reg;
    assign m_total_count     = total_out_reg;
    assign m_is_still        = still_out_reg;
    assign m_count_capped    = capped_out_reg;

`ifndef NO_ASSERTIONS
    // the count unit only runs while the sequencer waits on it
    a_busy_state: assert property (@(posedge aclk) disable iff (!aresetn)
        cnt_stat.busy |-> state_reg == S_COUNT)
        else $error("count unit busy outside the count state");
`endif

endmodule

[tb/tb_piece_count_stable_weigh_core.sv]
`timescale 1ns / 1ps
// tb_piece_count_stable_weigh_core: self-checking bench for the piece count / stable weigh core
// depends on pcsw_pkg and piece_count_stable_weigh_core; each result word is checked against
// an in-bench model of the counting loop and the stable-weight tracker
module tb_piece_count_stable_weigh_core;
    import pcsw_pkg::*;

    localparam int WATCHDOG_LIMIT = 20000;
    localparam int SETTLE_CYCLES  = 32;
    localparam int MAX_SHOWN      = 10;

    typedef struct packed {
        logic [HELD_W-1:0]  held;
        logic [COUNT_W-1:0] normal;
        logic [COUNT_W-1:0] odd;
        logic [COUNT_W-1:0] total;
        logic               still;
        logic               capped;
    } weigh_word_t;

    logic                   aclk = 1'b0;
    logic                   aresetn = 1'b0;
    logic                   s_valid = 1'b0;
    logic                   s_ready;
    logic [WEIGHT_BITS-1:0] s_sample_weight = '0;
    logic                   m_valid;
    logic                   m_ready = 1'b0;
    logic [HELD_W-1:0]      m_held_weight_out;
    logic [COUNT_W-1:0]     m_normal_count;
    logic [COUNT_W-1:0]     m_odd_count;
    logic [COUNT_W-1:0]     m_total_count;
    logic                   m_is_still;
    logic                   m_count_capped;
    logic                   cfg_we = 1'b0;
    cfg_reg_t               cfg_addr = REG_PIECE_AVERAGE;
    logic [CFG_W-1:0]       cfg_wdata = '0;

    // scale settings as the core should hold them (reset values)
    longint            avg_g = 100;
    longint            tol_g = 10;
    int                odd_low_g = 20;
    int                odd_high_g = 40;
    longint            still_thr_g = 5;
    int                still_need = 10;

    // stable-weight history
    logic [HELD_W-1:0] prev_weight = '0;
    logic [HELD_W-1:0] held_g = '0;
    int                still_run = 0;

    weigh_word_t       expected_weighs[$];
    int                error_count = 0;
    int                quiet_cycles = 0;
    bit                no_idle = 1'b0;

    piece_count_stable_weigh_core dut (
        .aclk              (aclk),
        .aresetn           (aresetn),
        .s_valid           (s_valid),
        .s_ready           (s_ready),
        .s_sample_weight   (s_sample_weight),
        .m_valid           (m_valid),
        .m_ready           (m_ready),
        .m_held_weight_out (m_held_weight_out),
        .m_normal_count    (m_normal_count),
        .m_odd_count       (m_odd_count),
        .m_total_count     (m_total_count),
        .m_is_still        (m_is_still),
        .m_count_capped    (m_count_capped),
        .cfg_we            (cfg_we),
        .cfg_addr          (cfg_addr),
        .cfg_wdata         (cfg_wdata)
    );

    always begin
        #4 aclk = 1'b1;
        #4 aclk = 1'b0;
    end

    // clip a raw count to the output field
    function automatic logic [COUNT_W-1:0] clip_count(input int c);
        return COUNT_W'((c > COUNT_OUT_MAX) ? COUNT_OUT_MAX : c);
    endfunction

    // count pieces in one sample and advance the stable-weight tracker
    function automatic weigh_word_t weigh_sample(input logic [WEIGHT_BITS-1:0] raw);
        longint      w;
        longint      margin;
        longint      odd_lo;
        longint      odd_hi;
        longint      rem;
        longint      delta;
        int          normal;
        int          odd;
        int          steps;
        logic        capped;
        logic        still;
        weigh_word_t r;
        // negative samples read as empty pan
        w = raw[WEIGHT_BITS-1] ? 64'sd0 : longint'(raw);
        margin = avg_g - tol_g;
        odd_lo = avg_g + odd_low_g;
        odd_hi = avg_g + odd_high_g;
        rem = w;
        normal = 0;
        odd = 0;
        steps = 0;
        capped = 1'b0;
        while (rem >= margin) begin
            if (steps >= MAX_PIECES) begin
                capped = 1'b1;
                break;
            end
            if (rem >= odd_lo && rem <= odd_hi) begin
                odd++;
            end else begin
                normal++;
            end
            steps++;
            rem -= avg_g;
        end
        // stability run against the previous clamped sample
        delta = w - longint'(prev_weight);
        if (delta < 0) begin
            delta = -delta;
        end
        still = (delta <= still_thr_g);
        if (still) begin
            if (still_run < 255) begin
                still_run++;
            end
            if (still_run >= still_need) begin
                held_g = w[HELD_W-1:0];
                still_run = still_need;
            end
        end else begin
            still_run = 0;
        end
        prev_weight = w[HELD_W-1:0];
        r.held   = held_g;
        r.normal = clip_count(normal);
        r.odd    = clip_count(odd);
        r.total  = clip_count(normal + odd);
        r.still  = still;
        r.capped = capped;
        return r;
    endfunction

    // offer one sample word, record its expected result once taken
    task automatic send_sample(input logic [WEIGHT_BITS-1:0] raw);
        if (!no_idle && $urandom_range(99) < 33) begin
            s_valid <= 1'b0;
            repeat ($urandom_range(4, 1)) @(posedge aclk);
        end
        s_valid <= 1'b1;
        s_sample_weight <= raw;
        @(posedge aclk);
        while (!s_ready) @(posedge aclk);
        expected_weighs.push_back(weigh_sample(raw));
    endtask

    // stop sending and let every outstanding result come back
    task automatic wait_drained();
        s_valid <= 1'b0;
        while (expected_weighs.size() != 0) @(posedge aclk);
        repeat (4) @(posedge aclk);
    endtask

    // register write, only called while the core is idle
    task automatic write_setting(input cfg_reg_t idx, input logic [CFG_W-1:0] value);
        cfg_we <= 1'b1;
        cfg_addr <= idx;
        cfg_wdata <= value;
        @(posedge aclk);
        cfg_we <= 1'b0;
        case (idx)
            REG_PIECE_AVERAGE:      avg_g = longint'(value);
            REG_PIECE_TOLERANCE:    tol_g = longint'(value);
            REG_ODD_LOW_OFFSET:     odd_low_g = $signed(value);
            REG_ODD_HIGH_OFFSET:    odd_high_g = $signed(value);
            REG_STILL_THRESHOLD:    still_thr_g = longint'(value);
            REG_STILL_COUNT_NEEDED: still_need = int'(value[NEED_W-1:0]);
            default: ;
        endcase
        @(posedge aclk);
    endtask

    // field extremes and window edges under the reset settings
    task automatic test_sample_extremes();
        send_sample(WEIGHT_BITS'(0));
        send_sample(WEIGHT_BITS'(524287));
        send_sample(WEIGHT_BITS'(-524288));
        send_sample(WEIGHT_BITS'(-1));
        send_sample(WEIGHT_BITS'(1));
        send_sample(WEIGHT_BITS'(89));
        send_sample(WEIGHT_BITS'(90));
        send_sample(WEIGHT_BITS'(120));
        send_sample(WEIGHT_BITS'(140));
        send_sample(WEIGHT_BITS'(141));
        wait_drained();
    endtask

    // zero average, negative margin, empty and full odd windows, still corner cases
    task automatic test_corner_settings();
        // zero average never shrinks the remainder
        write_setting(REG_PIECE_AVERAGE, 16'd0);
        write_setting(REG_PIECE_TOLERANCE, 16'd0);
        send_sample(WEIGHT_BITS'(500));
        wait_drained();
        // tolerance above average gives a negative margin
        write_setting(REG_PIECE_AVERAGE, 16'd50);
        write_setting(REG_PIECE_TOLERANCE, 16'd200);
        send_sample(WEIGHT_BITS'(0));
        send_sample(WEIGHT_BITS'(-5));
        wait_drained();
        // low edge above high edge: nothing is odd
        write_setting(REG_PIECE_AVERAGE, 16'd100);
        write_setting(REG_PIECE_TOLERANCE, 16'd0);
        write_setting(REG_ODD_LOW_OFFSET, 16'd40);
        write_setting(REG_ODD_HIGH_OFFSET, 16'd20);
        send_sample(WEIGHT_BITS'(130));
        wait_drained();
        // widest window, largest average and tolerance
        write_setting(REG_PIECE_AVERAGE, 16'hFFFF);
        write_setting(REG_PIECE_TOLERANCE, 16'hFFFF);
        write_setting(REG_ODD_LOW_OFFSET, 16'h8000);
        write_setting(REG_ODD_HIGH_OFFSET, 16'h7FFF);
        send_sample(WEIGHT_BITS'(524287));
        wait_drained();
        // one gram per piece runs into the count cap
        write_setting(REG_PIECE_AVERAGE, 16'd1);
        write_setting(REG_PIECE_TOLERANCE, 16'd0);
        send_sample(WEIGHT_BITS'(2000));
        wait_drained();
        // zero run length: every still sample is held at once
        write_setting(REG_STILL_THRESHOLD, 16'd0);
        write_setting(REG_STILL_COUNT_NEEDED, 16'd0);
        send_sample(WEIGHT_BITS'(700));
        send_sample(WEIGHT_BITS'(700));
        send_sample(WEIGHT_BITS'(701));
        wait_drained();
        // widest threshold, hold on the first still sample
        write_setting(REG_STILL_THRESHOLD, 16'hFFFF);
        write_setting(REG_STILL_COUNT_NEEDED, 16'd1);
        send_sample(WEIGHT_BITS'(0));
        send_sample(WEIGHT_BITS'(524287));
        wait_drained();
    endtask

    // phases of random settings with bursts of near-equal samples on the pan
    task automatic test_random_traffic();
        int                     avg_v;
        int                     tol_v;
        int                     lo_v;
        int                     hi_v;
        int                     thr_v;
        int                     need_v;
        int                     items;
        int                     left;
        int                     sel;
        bit                     long_hold;
        longint                 base;
        longint                 value;
        longint                 jit;
        longint                 tolc;
        logic [WEIGHT_BITS-1:0] raw;
        for (int phase = 0; phase < 7; phase++) begin
            wait_drained();
            no_idle = (phase == 1);
            long_hold = (phase == 3);
            avg_v = $urandom_range(2000, 20);
            tol_v = ($urandom_range(9) == 0) ? $urandom_range(5000, avg_v) :
                    $urandom_range(avg_v, 0);
            lo_v = int'($urandom_range(200)) - 100;
            hi_v = lo_v + int'($urandom_range(150)) - 30;
            thr_v = $urandom_range(30);
            need_v = $urandom_range(15, 1);
            case (phase)
                2: begin
                    avg_v = 65535;
                    tol_v = 0;
                    lo_v = -32768;
                    hi_v = 32767;
                    thr_v = 65535;
                    need_v = 1;
                end
                3: begin
                    need_v = 255;
                    thr_v = $urandom_range(10, 3);
                end
                4: begin
                    avg_v = $urandom_range(8, 1);
                    thr_v = 0;
                end
                5: begin
                    avg_v = 1;
                    tol_v = 65535;
                end
                default: ;
            endcase
            write_setting(REG_PIECE_AVERAGE, CFG_W'(avg_v));
            write_setting(REG_PIECE_TOLERANCE, CFG_W'(tol_v));
            write_setting(REG_ODD_LOW_OFFSET, CFG_W'(lo_v));
            write_setting(REG_ODD_HIGH_OFFSET, CFG_W'(hi_v));
            write_setting(REG_STILL_THRESHOLD, CFG_W'(thr_v));
            write_setting(REG_STILL_COUNT_NEEDED, CFG_W'(need_v));
            items = long_hold ? 270 : 50;
            left = 0;
            base = 0;
            tolc = (tol_g > 1000) ? 1000 : tol_g;
            jit = (still_thr_g / 2 > 64) ? 64 : still_thr_g / 2;
            for (int i = 0; i < items; i++) begin
                if (left == 0) begin
                    base = avg_g * longint'($urandom_range(12)) +
                           longint'($urandom_range(2 * tolc)) - tolc;
                    left = long_hold ? items : $urandom_range(still_need + 5, 1);
                end
                left--;
                sel = long_hold ? 99 : $urandom_range(99);
                if (sel < 8) begin
                    raw = WEIGHT_BITS'($urandom);
                end else if (sel < 14) begin
                    raw = WEIGHT_BITS'(-longint'($urandom_range(1000, 1)));
                end else begin
                    value = base + longint'($urandom_range(2 * jit)) - jit;
                    if (value < 0) begin
                        value = 0;
                    end else if (value > 524287) begin
                        value = 524287;
                    end
                    raw = WEIGHT_BITS'(value);
                end
                send_sample(raw);
                if ($urandom_range(99) < 2) begin
                    wait_drained();
                end
            end
        end
        no_idle = 1'b0;
        wait_drained();
    endtask

    // result side back-pressure
    always @(posedge aclk) begin
        m_ready <= no_idle || ($urandom_range(99) >= 33);
    end

    // compare each result word with the oldest expectation, watch for a hang
    always @(posedge aclk) begin : check_results
        weigh_word_t want;
        weigh_word_t got;
        if (aresetn) begin
            if (m_valid && m_ready) begin
                got = {m_held_weight_out, m_normal_count, m_odd_count, m_total_count,
                       m_is_still, m_count_capped};
                if (expected_weighs.size() == 0) begin
                    error_count++;
                    if (error_count <= MAX_SHOWN) begin
                        $display("unexpected result word: held %0d normal %0d odd %0d",
                                 got.held, got.normal, got.odd);
                    end
                end else begin
                    want = expected_weighs.pop_front();
                    if (got !== want) begin
                        error_count++;
                        if (error_count <= MAX_SHOWN) begin
                            $display("mismatch (exp/act): held %0d/%0d normal %0d/%0d odd %0d/%0d",
                                     want.held, got.held, want.normal, got.normal,
                                     want.odd, got.odd);
                            $display("  total %0d/%0d still %0b/%0b capped %0b/%0b",
                                     want.total, got.total, want.still, got.still,
                                     want.capped, got.capped);
                        end
                    end
                end
            end
            if ((s_valid && s_ready) || (m_valid && m_ready)) begin
                quiet_cycles = 0;
            end else begin
                quiet_cycles++;
            end
            if (quiet_cycles >= WATCHDOG_LIMIT) begin
                $display("timeout: no word moved in %0d cycles", WATCHDOG_LIMIT);
                $display("Simulation FAILED");
                $finish;
            end
        end
    end

    initial begin
        repeat (11) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);
        test_sample_extremes();
        test_corner_settings();
        test_random_traffic();
        wait_drained();
        repeat (SETTLE_CYCLES) @(posedge aclk);
        if (error_count == 0 && expected_weighs.size() == 0) begin
            $display("Simulation PASSED");
        end else begin
            $display("Simulation FAILED");
        end
        $finish;
    end

endmodule
